// ----- sv/srv_pkg.sv -----
`default_nettype none
package srv_pkg;

	localparam logic [1:0] OP_WR_POS = 2'd0;
	localparam logic [1:0] OP_WR_NB  = 2'd1;
	localparam logic [1:0] OP_VEL    = 2'd2;
	localparam logic [1:0] OP_RSVD   = 2'd3;

	localparam logic [2:0] CFG_TARGET   = 3'd0;
	localparam logic [2:0] CFG_STIFF    = 3'd1;
	localparam logic [2:0] CFG_REPULSE  = 3'd2;
	localparam logic [2:0] CFG_CONTACT  = 3'd3;
	localparam logic [2:0] CFG_EPSILON  = 3'd4;
	localparam logic [2:0] CFG_ACTIVE   = 3'd5;

	localparam int SQRT_STEPS = 15;
	localparam int DIV_STEPS  = 29;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_WR_POS,
		DP_WR_NB,
		DP_START,
		DP_LD_CTR,
		DP_RD_TAB,
		DP_RD_NB,
		DP_RD_SCAN,
		DP_DIFF,
		DP_SQX,
		DP_SQY,
		DP_SQRT_STEP,
		DP_MUL_TD,
		DP_DIV_STEP,
		DP_TERM,
		DP_MUL_ST
	} dp_op_t;

	typedef enum logic [1:0] {
		DPX_NONE,
		DPX_MUL_G,
		DPX_ROUND_G,
		DPX_ACC
	} dp_aux_t;

	typedef struct packed {
		dp_op_t  op;
		dp_aux_t aux;
		logic    axis;
		logic    use_dir;
	} srv_cmd_t;

	typedef struct packed {
		logic len_gt_eps;
		logic in_contact;
	} srv_stat_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_LDC,
		S_NCHK,
		S_NPOS,
		S_NDIFF,
		S_NSQX,
		S_NSQY,
		S_SQRT,
		S_TD,
		S_DIV,
		S_TERM,
		S_MST,
		S_NACC,
		S_RCHK,
		S_RDIFF,
		S_RSQX,
		S_RSQY,
		S_RCND,
		S_RMUL,
		S_RRND,
		S_RACC,
		S_DONE
	} srv_state_t;

endpackage
`default_nettype wire

// ----- sv/srv_datapath.sv -----
`default_nettype none
module srv_datapath import srv_pkg::*; #(
	parameter int MAX_KNOTS    = 64,
	parameter int NEIGHBOR_CAP = 4,
	localparam int KW  = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1,
	localparam int SW  = (NEIGHBOR_CAP > 1) ? $clog2(NEIGHBOR_CAP) : 1,
	localparam int CW  = $clog2(NEIGHBOR_CAP + 1),
	localparam int AW  = $clog2(MAX_KNOTS + 1),
	localparam int TAW = (MAX_KNOTS * NEIGHBOR_CAP > 1) ? $clog2(MAX_KNOTS * NEIGHBOR_CAP) : 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire srv_cmd_t           cmd,
	input  wire logic [SW-1:0]      slot,
	input  wire logic [AW-1:0]      scan,
	output srv_stat_t               stat,
	output logic [CW-1:0]           n_cnt,
	output logic [AW-1:0]           act,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [13:0]        cfg_wdata,
	input  wire logic [5:0]         knot_index,
	input  wire logic [13:0]        pos_x,
	input  wire logic [13:0]        pos_y,
	input  wire logic [1:0]         neighbor_slot,
	input  wire logic [5:0]         neighbor_index,
	input  wire logic [2:0]         neighbor_count,
	output logic [5:0]              result_knot,
	output logic signed [31:0]      vel_x,
	output logic signed [31:0]      vel_y,
	output logic                    saturated
);

	function automatic logic [KW-1:0] wrap(input logic [5:0] v);
		logic [16:0] r;
		r = 17'(v);
		for (int j = 5; j >= 0; j--) begin
			if (r >= 17'(MAX_KNOTS << j)) r = r - 17'(MAX_KNOTS << j);
		end
		return KW'(r);
	endfunction

	logic [13:0] td_q, cd_q;
	logic [7:0]  st_q, g_q, eps_q;
	logic [6:0]  active_q;

	logic [27:0] pos_mem [MAX_KNOTS];
	logic [5:0]  tab_mem [MAX_KNOTS * NEIGHBOR_CAP];
	logic [CW-1:0] cnt_mem [MAX_KNOTS];
	logic [MAX_KNOTS-1:0] cnt_vld_q;

	logic [27:0]   pos_rd_q;
	logic [5:0]    tab_rd_q;
	logic [CW-1:0] cnt_rd_q;
	logic          cntv_q;

	logic [KW-1:0]  k_q;
	logic [5:0]     kraw_q;
	logic [13:0]    cx_q, cy_q;
	logic [CW-1:0]  n_q;
	logic [27:0]    cd2_q;
	logic signed [14:0] dx_q, dy_q;
	logic [29:0]    s_q, sq_sh_q;
	logic [15:0]    rem_q;
	logic [14:0]    root_q;
	logic [28:0]    num_q;
	logic [15:0]    drem_q;
	logic           neg_q;
	logic signed [17:0] t_q;
	logic signed [23:0] p_q;
	logic signed [31:0] term_q, vel_x_q, vel_y_q;
	logic           sat_q;

	logic [KW-1:0]  pos_ra, k_in;
	logic [TAW-1:0] tab_wa, tab_ra;
	logic           slot_ok;
	logic [CW-1:0]  cnt_in;

	logic signed [14:0] d_sel;
	logic signed [17:0] ma, mb, q_s, t_next;
	logic signed [35:0] mp;
	logic [35:0]        mp_abs;
	logic [17:0]        rem_n, trial;
	logic               sq_ge;
	logic [16:0]        drem_n;
	logic               div_ge;
	logic [22:0]        p_abs;
	logic [22:0]        rmag;
	logic signed [31:0] term_rnd, acc_old, acc_new;
	logic signed [32:0] acc_sum;
	logic               acc_clip;

	assign k_in   = wrap(knot_index);
	assign tab_wa = TAW'(int'(k_in) * NEIGHBOR_CAP + int'(neighbor_slot));
	assign tab_ra = TAW'(int'(k_q) * NEIGHBOR_CAP + int'(slot));
	assign slot_ok = int'(neighbor_slot) < NEIGHBOR_CAP;
	assign cnt_in = (int'(neighbor_count) > NEIGHBOR_CAP) ? CW'(NEIGHBOR_CAP)
	                                                       : CW'(neighbor_count);

	always_comb begin
		case (cmd.op)
			DP_START:   pos_ra = k_in;
			DP_RD_NB:   pos_ra = wrap(tab_rd_q);
			DP_RD_SCAN: pos_ra = scan[KW-1:0];
			default:    pos_ra = k_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.op == DP_WR_POS) pos_mem[k_in] <= {pos_y, pos_x};
		if (cmd.op == DP_WR_NB && slot_ok) tab_mem[tab_wa] <= neighbor_index;
		if (cmd.op == DP_WR_NB) cnt_mem[k_in] <= cnt_in;
		pos_rd_q <= pos_mem[pos_ra];
		tab_rd_q <= tab_mem[tab_ra];
		cnt_rd_q <= cnt_mem[k_in];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
		end else if (cmd.op == DP_WR_NB) begin
			cnt_vld_q[k_in] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			td_q     <= 14'd640;
			st_q     <= 8'd38;
			g_q      <= 8'd24;
			cd_q     <= 14'd320;
			eps_q    <= 8'd1;
			active_q <= 7'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TARGET:  td_q     <= cfg_wdata;
				CFG_STIFF:   st_q     <= cfg_wdata[7:0];
				CFG_REPULSE: g_q      <= cfg_wdata[7:0];
				CFG_CONTACT: cd_q     <= cfg_wdata;
				CFG_EPSILON: eps_q    <= cfg_wdata[7:0];
				CFG_ACTIVE:  active_q <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	assign d_sel = cmd.axis ? dy_q : dx_q;

	always_comb begin
		case (cmd.op)
			DP_START: begin
				ma = $signed({4'b0, cd_q});
				mb = $signed({4'b0, cd_q});
			end
			DP_SQX: begin
				ma = 18'(dx_q);
				mb = 18'(dx_q);
			end
			DP_SQY: begin
				ma = 18'(dy_q);
				mb = 18'(dy_q);
			end
			DP_MUL_TD: begin
				ma = 18'(d_sel);
				mb = $signed({4'b0, td_q});
			end
			DP_MUL_ST: begin
				ma = $signed({10'b0, st_q});
				mb = t_q;
			end
			default: begin
				if (cmd.aux == DPX_MUL_G) begin
					ma = $signed({10'b0, g_q});
					mb = 18'(d_sel);
				end else begin
					ma = '0;
					mb = '0;
				end
			end
		endcase
	end

	assign mp     = ma * mb;
	assign mp_abs = mp[35] ? 36'(-mp) : 36'(mp);

	// one root digit per step
	assign rem_n = {rem_q, sq_sh_q[29:28]};
	assign trial = {1'b0, root_q, 2'b01};
	assign sq_ge = rem_n >= trial;

	// one quotient bit per step, remainder stays below len
	assign drem_n = {drem_q, num_q[28]};
	assign div_ge = drem_n >= {2'b0, root_q};

	assign q_s = neg_q ? -$signed({1'b0, num_q[16:0]}) : $signed({1'b0, num_q[16:0]});

	always_comb begin
		if (cmd.use_dir)    t_next = q_s - 18'(d_sel);
		else if (cmd.axis) t_next = -18'(dy_q);
		else               t_next = $signed({4'b0, td_q}) - 18'(dx_q);
	end

	assign p_abs    = p_q[23] ? 23'(-p_q) : 23'(p_q);
	assign rmag     = (p_abs + 23'd8) >> 4;
	assign term_rnd = p_q[23] ? -$signed(32'(rmag)) : $signed(32'(rmag));

	assign acc_old = cmd.axis ? vel_y_q : vel_x_q;
	assign acc_sum = 33'(acc_old) + 33'(term_q);
	always_comb begin
		acc_clip = 1'b1;
		if (acc_sum > 33'sh0_7FFF_FFFF)       acc_new = 32'sh7FFF_FFFF;
		else if (acc_sum < -33'sh0_8000_0000) acc_new = 32'sh8000_0000;
		else begin
			acc_new  = acc_sum[31:0];
			acc_clip = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_START: begin
				k_q     <= k_in;
				kraw_q  <= knot_index;
				cd2_q   <= mp[27:0];
				cntv_q  <= cnt_vld_q[k_in];
				vel_x_q <= '0;
				vel_y_q <= '0;
				sat_q   <= 1'b0;
			end
			DP_LD_CTR: begin
				cx_q <= pos_rd_q[13:0];
				cy_q <= pos_rd_q[27:14];
				n_q  <= cntv_q ? cnt_rd_q : '0;
			end
			DP_DIFF: begin
				dx_q <= $signed({1'b0, cx_q}) - $signed({1'b0, pos_rd_q[13:0]});
				dy_q <= $signed({1'b0, cy_q}) - $signed({1'b0, pos_rd_q[27:14]});
			end
			DP_SQX: s_q <= mp[29:0];
			DP_SQY: begin
				s_q     <= s_q + mp[29:0];
				sq_sh_q <= s_q + mp[29:0];
				rem_q   <= '0;
				root_q  <= '0;
			end
			DP_SQRT_STEP: begin
				sq_sh_q <= {sq_sh_q[27:0], 2'b00};
				rem_q   <= sq_ge ? 16'(rem_n - trial) : rem_n[15:0];
				root_q  <= {root_q[13:0], sq_ge};
			end
			DP_MUL_TD: begin
				num_q  <= mp_abs[28:0] + 29'(root_q >> 1);
				neg_q  <= mp[35];
				drem_q <= '0;
			end
			DP_DIV_STEP: begin
				drem_q <= div_ge ? 16'(drem_n - {2'b0, root_q}) : drem_n[15:0];
				num_q  <= {num_q[27:0], div_ge};
			end
			DP_TERM:   t_q    <= t_next;
			DP_MUL_ST: term_q <= mp[31:0];
			default: begin
				case (cmd.aux)
					DPX_MUL_G:   p_q    <= mp[23:0];
					DPX_ROUND_G: term_q <= term_rnd;
					DPX_ACC: begin
						if (cmd.axis) vel_y_q <= acc_new;
						else          vel_x_q <= acc_new;
						if (acc_clip) sat_q <= 1'b1;
					end
					default: ;
				endcase
			end
		endcase
	end

	assign stat.len_gt_eps = root_q > {7'b0, eps_q};
	assign stat.in_contact = (dx_q != 0) && (dy_q != 0) && (s_q <= {2'b0, cd2_q});
	assign n_cnt = n_q;
	assign act   = (int'(active_q) > MAX_KNOTS) ? AW'(MAX_KNOTS) : AW'(active_q);

	assign result_knot = kraw_q;
	assign vel_x       = vel_x_q;
	assign vel_y       = vel_y_q;
	assign saturated   = sat_q;

endmodule
`default_nettype wire

// ----- sv/srv_ctrl.sv -----
`default_nettype none
module srv_ctrl import srv_pkg::*; #(
	parameter int MAX_KNOTS    = 64,
	parameter int NEIGHBOR_CAP = 4,
	localparam int SW = (NEIGHBOR_CAP > 1) ? $clog2(NEIGHBOR_CAP) : 1,
	localparam int CW = $clog2(NEIGHBOR_CAP + 1),
	localparam int AW = $clog2(MAX_KNOTS + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [1:0]    opcode,
	output logic               busy,
	output logic               result_valid,
	output srv_cmd_t           cmd,
	output logic [SW-1:0]      slot,
	output logic [AW-1:0]      scan,
	input  wire srv_stat_t     stat,
	input  wire logic [CW-1:0] n_cnt,
	input  wire logic [AW-1:0] act
);

	srv_state_t state_q, state_d;
	logic [CW-1:0] slot_q, slot_d;
	logic [AW-1:0] scan_q, scan_d;
	logic [4:0]    it_q, it_d;
	logic          axis_q, axis_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			slot_q  <= '0;
			scan_q  <= '0;
			it_q    <= '0;
			axis_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			slot_q  <= slot_d;
			scan_q  <= scan_d;
			it_q    <= it_d;
			axis_q  <= axis_d;
		end
	end

	always_comb begin
		state_d = state_q;
		slot_d  = slot_q;
		scan_d  = scan_q;
		it_d    = it_q;
		axis_d  = axis_q;
		cmd.op      = DP_NOP;
		cmd.aux     = DPX_NONE;
		cmd.axis    = axis_q;
		cmd.use_dir = stat.len_gt_eps;
		result_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (opcode)
						OP_WR_POS: cmd.op = DP_WR_POS;
						OP_WR_NB:  cmd.op = DP_WR_NB;
						OP_VEL: begin
							cmd.op  = DP_START;
							state_d = S_LDC;
						end
						default: ;
					endcase
				end
			end
			S_LDC: begin
				cmd.op  = DP_LD_CTR;
				slot_d  = '0;
				state_d = S_NCHK;
			end
			S_NCHK: begin
				if (slot_q == n_cnt) begin
					scan_d  = '0;
					state_d = S_RCHK;
				end else begin
					cmd.op  = DP_RD_TAB;
					state_d = S_NPOS;
				end
			end
			S_NPOS: begin
				cmd.op  = DP_RD_NB;
				state_d = S_NDIFF;
			end
			S_NDIFF: begin
				cmd.op  = DP_DIFF;
				state_d = S_NSQX;
			end
			S_NSQX: begin
				cmd.op  = DP_SQX;
				state_d = S_NSQY;
			end
			S_NSQY: begin
				cmd.op  = DP_SQY;
				it_d    = '0;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.op = DP_SQRT_STEP;
				it_d   = it_q + 5'd1;
				if (it_q == 5'(SQRT_STEPS - 1)) begin
					axis_d  = 1'b0;
					state_d = S_TD;
				end
			end
			S_TD: begin
				if (stat.len_gt_eps) begin
					cmd.op  = DP_MUL_TD;
					it_d    = '0;
					state_d = S_DIV;
				end else begin
					state_d = S_TERM;
				end
			end
			S_DIV: begin
				cmd.op = DP_DIV_STEP;
				it_d   = it_q + 5'd1;
				if (it_q == 5'(DIV_STEPS - 1)) state_d = S_TERM;
			end
			S_TERM: begin
				cmd.op  = DP_TERM;
				state_d = S_MST;
			end
			S_MST: begin
				cmd.op  = DP_MUL_ST;
				state_d = S_NACC;
			end
			S_NACC: begin
				cmd.aux = DPX_ACC;
				if (!axis_q) begin
					axis_d  = 1'b1;
					state_d = S_TD;
				end else begin
					slot_d  = slot_q + 1'b1;
					state_d = S_NCHK;
				end
			end
			S_RCHK: begin
				if (scan_q == act) begin
					state_d = S_DONE;
				end else begin
					cmd.op  = DP_RD_SCAN;
					state_d = S_RDIFF;
				end
			end
			S_RDIFF: begin
				cmd.op  = DP_DIFF;
				state_d = S_RSQX;
			end
			S_RSQX: begin
				cmd.op  = DP_SQX;
				state_d = S_RSQY;
			end
			S_RSQY: begin
				cmd.op  = DP_SQY;
				state_d = S_RCND;
			end
			S_RCND: begin
				if (stat.in_contact) begin
					axis_d  = 1'b0;
					state_d = S_RMUL;
				end else begin
					scan_d  = scan_q + 1'b1;
					state_d = S_RCHK;
				end
			end
			S_RMUL: begin
				cmd.aux = DPX_MUL_G;
				state_d = S_RRND;
			end
			S_RRND: begin
				cmd.aux = DPX_ROUND_G;
				state_d = S_RACC;
			end
			S_RACC: begin
				cmd.aux = DPX_ACC;
				if (!axis_q) begin
					axis_d  = 1'b1;
					state_d = S_RMUL;
				end else begin
					scan_d  = scan_q + 1'b1;
					state_d = S_RCHK;
				end
			end
			S_DONE: begin
				result_valid = 1'b1;
				state_d      = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign slot = slot_q[SW-1:0];
	assign scan = scan_q;

endmodule
`default_nettype wire

// ----- sv/spring_rope_velocity_unit.sv -----
// Position and neighbor writes leave busy low, and the next item may follow.
// A velocity request keeps busy high while each neighbor is processed (with a divide per
// axis when the link is longer than epsilon) and each active knot is checked for contact.
// The bitwise root and the 29-step divide set the neighbor cost.
// The result shows for one cycle with result_valid; the receiver cannot stall it.
// Reset returns the config registers to their defaults and clears all neighbor counts; positions start unknown.
`default_nettype none
module spring_rope_velocity_unit import srv_pkg::*; #(
	parameter int MAX_KNOTS    = 64,
	parameter int NEIGHBOR_CAP = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  wire logic [1:0]   opcode,
	input  wire logic [5:0]   knot_index,
	input  wire logic [13:0]  pos_x,
	input  wire logic [13:0]  pos_y,
	input  wire logic [1:0]   neighbor_slot,
	input  wire logic [5:0]   neighbor_index,
	input  wire logic [2:0]   neighbor_count,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [13:0]  cfg_wdata,
	output logic              result_valid,
	output logic [5:0]        result_knot,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic              saturated
);

	localparam int SW = (NEIGHBOR_CAP > 1) ? $clog2(NEIGHBOR_CAP) : 1;
	localparam int CW = $clog2(NEIGHBOR_CAP + 1);
	localparam int AW = $clog2(MAX_KNOTS + 1);

	srv_cmd_t      cmd;
	srv_stat_t     stat;
	logic [SW-1:0] slot;
	logic [AW-1:0] scan, act;
	logic [CW-1:0] n_cnt;

	srv_ctrl #(.MAX_KNOTS(MAX_KNOTS), .NEIGHBOR_CAP(NEIGHBOR_CAP)) u_ctrl (
		.clk, .arst_n, .start, .opcode, .busy, .result_valid,
		.cmd, .slot, .scan, .stat, .n_cnt, .act
	);

	srv_datapath #(.MAX_KNOTS(MAX_KNOTS), .NEIGHBOR_CAP(NEIGHBOR_CAP)) u_dp (
		.clk, .arst_n, .cmd, .slot, .scan, .stat, .n_cnt, .act,
		.cfg_we, .cfg_index, .cfg_wdata,
		.knot_index, .pos_x, .pos_y, .neighbor_slot, .neighbor_index, .neighbor_count,
		.result_knot, .vel_x, .vel_y, .saturated
	);

endmodule
`default_nettype wire

// ----- sv/srv_checker.sv -----
`default_nettype none
module srv_checker import srv_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [1:0] opcode,
	input wire logic       result_valid
);

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("result strobe longer than one cycle");

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("result outside a request");

	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode != OP_VEL) |=> !busy) else $error("write item held the block");

	a_vel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_VEL) |=> busy) else $error("velocity item not taken");

endmodule

bind spring_rope_velocity_unit srv_checker u_srv_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.opcode(opcode), .result_valid(result_valid)
);
`default_nettype wire

// ----- bench/spring_rope_velocity_unit_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module spring_rope_velocity_unit_tb;
	import srv_pkg::*;

	typedef struct {
		logic [1:0]  op;
		logic [5:0]  knot;
		logic [13:0] x;
		logic [13:0] y;
		logic [1:0]  slot;
		logic [5:0]  nb;
		logic [2:0]  cnt;
	} knot_cmd_t;

	typedef struct {
		logic [5:0]         knot;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic               sat;
	} knot_vel_t;

	typedef struct {
		knot_cmd_t cmd;
		bit        typed;
		knot_vel_t vel;
	} table_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         opcode = '0;
	logic [5:0]         knot_index = '0;
	logic [13:0]        pos_x = '0;
	logic [13:0]        pos_y = '0;
	logic [1:0]         neighbor_slot = '0;
	logic [5:0]         neighbor_index = '0;
	logic [2:0]         neighbor_count = '0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [13:0]        cfg_wdata = '0;
	logic               result_valid;
	logic [5:0]         result_knot;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic               saturated;

	spring_rope_velocity_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .knot_index(knot_index), .pos_x(pos_x), .pos_y(pos_y),
		.neighbor_slot(neighbor_slot), .neighbor_index(neighbor_index),
		.neighbor_count(neighbor_count), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .result_valid(result_valid), .result_knot(result_knot),
		.vel_x(vel_x), .vel_y(vel_y), .saturated(saturated)
	);

	always #5 clk = ~clk;

	// shadow copy of the block's tables and registers
	int unsigned kx [64];
	int unsigned ky [64];
	int unsigned link_tab [256];
	int unsigned link_cnt [64];
	int unsigned m_target = 640, m_stiff = 38, m_gain = 24, m_contact = 320;
	int unsigned m_eps = 1, m_active = 0;

	knot_vel_t pending_vel [$];
	int        err_cnt = 0;
	int        vel_seen = 0;
	int        items_sent = 0;
	int        idle_pct = 0;

	function automatic longint isqrt(longint v);
		longint res = 0;
		longint b = longint'(1) << 40;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - res - b;
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint round_div(longint num, longint den);
		longint mag = num < 0 ? -num : num;
		longint q = (mag + den / 2) / den;
		return num < 0 ? -q : q;
	endfunction

	function automatic longint clamp_add(longint acc, longint v, inout bit flag);
		longint r = acc + v;
		if (r > 64'sd2147483647) begin
			r = 64'sd2147483647;
			flag = 1'b1;
		end
		if (r < -64'sd2147483648) begin
			r = -64'sd2147483648;
			flag = 1'b1;
		end
		return r;
	endfunction

	function automatic knot_vel_t knot_velocity(logic [5:0] k);
		knot_vel_t r;
		longint cx = kx[k], cy = ky[k];
		longint vx = 0, vy = 0, dx, dy, len, tx, ty;
		longint td = m_target, st = m_stiff, cd = m_contact;
		bit sat = 1'b0;
		int unsigned n = link_cnt[k], act, nbk;
		for (int i = 0; i < n; i++) begin
			nbk = link_tab[k * 4 + i];
			dx = cx - longint'(kx[nbk]);
			dy = cy - longint'(ky[nbk]);
			len = isqrt(dx * dx + dy * dy);
			if (len > longint'(m_eps)) begin
				tx = round_div(dx * td, len) - dx;
				ty = round_div(dy * td, len) - dy;
			end else begin
				tx = td - dx;
				ty = -dy;
			end
			vx = clamp_add(vx, st * tx, sat);
			vy = clamp_add(vy, st * ty, sat);
		end
		act = m_active > 64 ? 64 : m_active;
		for (int i = 0; i < act; i++) begin
			dx = cx - longint'(kx[i]);
			dy = cy - longint'(ky[i]);
			if (dx != 0 && dy != 0 && dx * dx + dy * dy <= cd * cd) begin
				vx = clamp_add(vx, round_div(longint'(m_gain) * dx, 16), sat);
				vy = clamp_add(vy, round_div(longint'(m_gain) * dy, 16), sat);
			end
		end
		r.knot = k;
		r.vx = vx[31:0];
		r.vy = vy[31:0];
		r.sat = sat;
		return r;
	endfunction

	// update shadow state for an accepted item and queue its velocity, if any
	task automatic apply_cmd(knot_cmd_t c, bit typed, knot_vel_t tv);
		case (c.op)
			OP_WR_POS: begin
				kx[c.knot] = c.x;
				ky[c.knot] = c.y;
			end
			OP_WR_NB: begin
				link_tab[c.knot * 4 + c.slot] = c.nb;
				link_cnt[c.knot] = c.cnt > 4 ? 4 : c.cnt;
			end
			OP_VEL: pending_vel.push_back(typed ? tv : knot_velocity(c.knot));
			default: ;
		endcase
	endtask

	task automatic send_item(knot_cmd_t c, bit typed = 1'b0, knot_vel_t tv = '{default: '0});
		opcode <= c.op;
		knot_index <= c.knot;
		pos_x <= c.x;
		pos_y <= c.y;
		neighbor_slot <= c.slot;
		neighbor_index <= c.nb;
		neighbor_count <= c.cnt;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		apply_cmd(c, typed, tv);
		items_sent++;
		// hold start high unless an idle gap follows
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			opcode <= 2'($urandom);
			knot_index <= 6'($urandom);
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_vel.size() != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [13:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_TARGET:  m_target = val;
			CFG_STIFF:   m_stiff = val[7:0];
			CFG_REPULSE: m_gain = val[7:0];
			CFG_CONTACT: m_contact = val;
			CFG_EPSILON: m_eps = val[7:0];
			CFG_ACTIVE:  m_active = val[6:0];
			default: ;
		endcase
	endtask

	function automatic logic [13:0] rand_coord();
		if ($urandom_range(99) < 30) return 14'($urandom);
		return 14'(7600 + $urandom_range(0, 800));
	endfunction

	function automatic knot_cmd_t rand_cmd();
		knot_cmd_t c;
		int unsigned pick = $urandom_range(99);
		c.op = pick < 30 ? OP_WR_POS : pick < 55 ? OP_WR_NB : pick < 92 ? OP_VEL : OP_RSVD;
		c.knot = 6'($urandom);
		c.x = rand_coord();
		c.y = rand_coord();
		c.slot = 2'($urandom);
		c.nb = $urandom_range(99) < 60 ? 6'(c.knot + $urandom_range(0, 2) - 1) : 6'($urandom);
		c.cnt = $urandom_range(99) < 80 ? 3'($urandom_range(0, 4)) : 3'($urandom);
		return c;
	endfunction

	// result checker: a velocity strobe is accepted at the edge ending its cycle
	always @(posedge clk) begin
		knot_vel_t e;
		if (result_valid) begin
			vel_seen++;
			if (pending_vel.size() == 0) begin
				$error("velocity for knot %0d with none pending", result_knot);
				err_cnt++;
			end else begin
				e = pending_vel.pop_front();
				if (result_knot !== e.knot) begin
					$error("result_knot expected %0d got %0d", e.knot, result_knot);
					err_cnt++;
				end
				if (vel_x !== e.vx) begin
					$error("vel_x expected %0d got %0d", e.vx, vel_x);
					err_cnt++;
				end
				if (vel_y !== e.vy) begin
					$error("vel_y expected %0d got %0d", e.vy, vel_y);
					err_cnt++;
				end
				if (saturated !== e.sat) begin
					$error("saturated expected %0d got %0d", e.sat, saturated);
					err_cnt++;
				end
			end
		end
	end

	table_row_t dir_tab [] = '{
		'{'{OP_WR_POS, 6'd0, 14'd0, 14'd0, 2'd0, 6'd0, 3'd0}, 0, '{default: '0}},
		'{'{OP_WR_POS, 6'd63, 14'h3fff, 14'h3fff, 2'd0, 6'd0, 3'd0}, 0, '{default: '0}},
		'{'{OP_WR_NB, 6'd0, 14'd0, 14'd0, 2'd0, 6'd0, 3'd1}, 0, '{default: '0}},
		// self link: zero length, direction falls back to +x
		'{'{OP_VEL, 6'd0, 14'd0, 14'd0, 2'd0, 6'd0, 3'd0}, 1, '{6'd0, 32'sd24320, 32'sd0, 1'b0}},
		'{'{OP_WR_NB, 6'd0, 14'd0, 14'd0, 2'd1, 6'd0, 3'd2}, 0, '{default: '0}},
		'{'{OP_VEL, 6'd0, 14'd0, 14'd0, 2'd0, 6'd0, 3'd0}, 1, '{6'd0, 32'sd48640, 32'sd0, 1'b0}},
		// count above the cap
		'{'{OP_WR_NB, 6'd63, 14'd0, 14'd0, 2'd3, 6'd0, 3'd7}, 0, '{default: '0}},
		'{'{OP_VEL, 6'd63, 14'd0, 14'd0, 2'd0, 6'd0, 3'd0}, 0, '{default: '0}},
		// opcode three is dropped
		'{'{OP_RSVD, 6'd5, 14'h3fff, 14'h3fff, 2'd3, 6'd63, 3'd7}, 0, '{default: '0}},
		'{'{OP_WR_NB, 6'd5, 14'd0, 14'd0, 2'd0, 6'd5, 3'd0}, 0, '{default: '0}},
		'{'{OP_VEL, 6'd5, 14'd0, 14'd0, 2'd0, 6'd0, 3'd0}, 1, '{6'd5, 32'sd0, 32'sd0, 1'b0}},
		'{'{OP_WR_POS, 6'd2, 14'h3fff, 14'd0, 2'd0, 6'd0, 3'd0}, 0, '{default: '0}},
		'{'{OP_WR_NB, 6'd2, 14'd0, 14'd0, 2'd0, 6'd0, 3'd1}, 0, '{default: '0}},
		'{'{OP_VEL, 6'd2, 14'd0, 14'd0, 2'd0, 6'd0, 3'd0}, 0, '{default: '0}},
		'{'{OP_WR_POS, 6'd1, 14'd100, 14'd60, 2'd0, 6'd0, 3'd0}, 0, '{default: '0}},
		'{'{OP_WR_NB, 6'd1, 14'd0, 14'd0, 2'd2, 6'd1, 3'd3}, 0, '{default: '0}},
		'{'{OP_VEL, 6'd1, 14'd0, 14'd0, 2'd0, 6'd0, 3'd0}, 0, '{default: '0}},
		'{'{OP_VEL, 6'd63, 14'd0, 14'd0, 2'd0, 6'd0, 3'd0}, 0, '{default: '0}}
	};

	initial begin
		knot_cmd_t c;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		for (int i = 0; i < 64; i++) link_cnt[i] = 0;

		// fill every position and every link slot before any lookup
		for (int i = 0; i < 64; i++) begin
			c = rand_cmd();
			c.op = OP_WR_POS;
			c.knot = 6'(i);
			send_item(c);
		end
		for (int i = 0; i < 256; i++) begin
			c = rand_cmd();
			c.op = OP_WR_NB;
			c.knot = 6'(i / 4);
			c.slot = 2'(i % 4);
			send_item(c);
		end

		foreach (dir_tab[i]) send_item(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].vel);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				1: begin
					write_reg(CFG_TARGET, 14'h3fff);
					write_reg(CFG_STIFF, 14'd255);
					write_reg(CFG_REPULSE, 14'd255);
					write_reg(CFG_CONTACT, 14'h3fff);
					write_reg(CFG_EPSILON, 14'd255);
					write_reg(CFG_ACTIVE, 14'd127);
				end
				2: begin
					write_reg(CFG_TARGET, 14'd0);
					write_reg(CFG_STIFF, 14'd0);
					write_reg(CFG_REPULSE, 14'd0);
					write_reg(CFG_CONTACT, 14'd0);
					write_reg(CFG_EPSILON, 14'd0);
					write_reg(CFG_ACTIVE, 14'd0);
				end
				3, 4, 5: begin
					write_reg(CFG_TARGET, 14'($urandom_range(0, 1200)));
					write_reg(CFG_STIFF, 14'($urandom_range(0, 255)));
					write_reg(CFG_REPULSE, 14'($urandom_range(0, 255)));
					write_reg(CFG_CONTACT, 14'($urandom_range(0, 700)));
					write_reg(CFG_EPSILON, 14'($urandom_range(0, 255)));
					write_reg(CFG_ACTIVE, 14'($urandom_range(0, 80)));
				end
				default: ;
			endcase
			idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 63 : 19;
			repeat (110) send_item(rand_cmd());
			drain();
		end

		$display("covered %0d items, %0d velocity results, six register settings",
			items_sent, vel_seen);
		$display("idle patterns: none, sender 63 percent, sender 19 percent");
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("timeout with %0d velocities pending", pending_vel.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire

// ----- spring_rope_velocity_unit.f -----
sv/srv_pkg.sv
sv/srv_datapath.sv
sv/srv_ctrl.sv
sv/spring_rope_velocity_unit.sv
sv/srv_checker.sv
bench/spring_rope_velocity_unit_tb.sv
